// ----- hw/rtl/tlv8_fragment_parser_unit_assert.svh -----
// assertion macros shared by the tlv8 fragment parser rtl
`ifndef TLV8_FRAGMENT_PARSER_UNIT_ASSERT_SVH
`define TLV8_FRAGMENT_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTH
// condition implies consequence in the same cycle
`define TLV8P_ASSERT_IMPL(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("assertion failed");
// condition implies consequence in the next cycle
`define TLV8P_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("assertion failed");
`else
`define TLV8P_ASSERT_IMPL(lbl, clk, rst_n, cond, cons)
`define TLV8P_ASSERT_NEXT(lbl, clk, rst_n, cond, cons)
`endif
`endif

// ----- hw/rtl/tlv8p_pkg.sv -----
// types and codes shared by the tlv8 fragment parser modules
package tlv8p_pkg;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_EMPTY  = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNC_HDR = 2'd1,
        ST_TRUNC_VAL = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] item_type;
        logic [7:0] value_byte;
        logic       starts_item;
        logic       frame_done;
        t_status    status;
    } t_result;

endpackage

// ----- hw/rtl/tlv8p_in_reg.sv -----
// input register stage of the tlv8 fragment parser
module tlv8p_in_reg
    import tlv8p_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    input  logic     i_advance,
    output logic     o_held,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_held = r_valid;
    assign o_item = r_item;

endmodule

// ----- hw/rtl/tlv8p_parse.sv -----
// record parser state and per-byte decode of the tlv8 fragment parser
`include "tlv8_fragment_parser_unit_assert.svh"
module tlv8p_parse
    import tlv8p_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_item i_item,
    output logic     o_has_result,
    output t_result  o_result
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_header_tag;
    logic [7:0] n_header_tag;
    logic [7:0] r_open_tag;
    logic [7:0] n_open_tag;
    logic       r_item_open;
    logic       n_item_open;
    logic [7:0] r_bytes_left;
    logic [7:0] n_bytes_left;
    logic       r_first_pending;
    logic       n_first_pending;

    logic       merge;
    logic       len_zero;
    logic [7:0] left_dec;
    logic [7:0] b;
    logic       last;

    assign b        = i_item.byte_in;
    assign last     = i_item.frame_last;
    assign merge    = r_item_open && (r_open_tag == r_header_tag);
    assign len_zero = (b == 8'd0);
    assign left_dec = 8'(r_bytes_left - 8'd1);

    // next state
    always_comb begin
        n_phase         = r_phase;
        n_header_tag    = r_header_tag;
        n_open_tag      = r_open_tag;
        n_item_open     = r_item_open;
        n_bytes_left    = r_bytes_left;
        n_first_pending = r_first_pending;
        case (r_phase)
            PH_LEN: begin
                if (len_zero) begin
                    if (!merge) begin
                        n_open_tag  = r_header_tag;
                        n_item_open = 1'b1;
                    end
                    n_phase = PH_TAG;
                end else if (!last) begin
                    if (!merge) begin
                        n_open_tag  = r_header_tag;
                        n_item_open = 1'b1;
                    end
                    n_first_pending = !merge;
                    n_bytes_left    = b;
                    n_phase         = PH_VAL;
                end
            end
            PH_VAL: begin
                n_bytes_left    = left_dec;
                n_first_pending = 1'b0;
                if (left_dec == 8'd0) begin
                    n_phase = PH_TAG;
                end
            end
            default: begin
                n_header_tag = b;
                if (!last) begin
                    n_phase = PH_LEN;
                end
            end
        endcase
        // frame end puts everything back to reset
        if (last) begin
            n_phase         = PH_TAG;
            n_header_tag    = 8'd0;
            n_open_tag      = 8'd0;
            n_item_open     = 1'b0;
            n_bytes_left    = 8'd0;
            n_first_pending = 1'b0;
        end
    end

    // result of this byte
    always_comb begin
        o_has_result         = 1'b0;
        o_result.kind        = KIND_STATUS;
        o_result.item_type   = r_header_tag;
        o_result.value_byte  = 8'd0;
        o_result.starts_item = 1'b0;
        o_result.frame_done  = last;
        o_result.status      = ST_OK;
        case (r_phase)
            PH_LEN: begin
                if (len_zero) begin
                    if (!merge) begin
                        o_has_result         = 1'b1;
                        o_result.kind        = KIND_EMPTY;
                        o_result.starts_item = 1'b1;
                    end else if (last) begin
                        o_has_result = 1'b1;
                    end
                end else if (last) begin
                    o_has_result    = 1'b1;
                    o_result.status = ST_TRUNC_VAL;
                end
            end
            PH_VAL: begin
                o_has_result         = 1'b1;
                o_result.kind        = KIND_VALUE;
                o_result.item_type   = r_open_tag;
                o_result.value_byte  = b;
                o_result.starts_item = r_first_pending;
                if (last && (left_dec != 8'd0)) begin
                    o_result.status = ST_TRUNC_VAL;
                end
            end
            default: begin
                o_result.item_type = b;
                if (last) begin
                    o_has_result    = 1'b1;
                    o_result.status = ST_TRUNC_HDR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_TAG;
            r_header_tag    <= 8'd0;
            r_open_tag      <= 8'd0;
            r_item_open     <= 1'b0;
            r_bytes_left    <= 8'd0;
            r_first_pending <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_header_tag    <= n_header_tag;
            r_open_tag      <= n_open_tag;
            r_item_open     <= n_item_open;
            r_bytes_left    <= n_bytes_left;
            r_first_pending <= n_first_pending;
        end
    end

    `TLV8P_ASSERT_IMPL(a_val_has_bytes, i_clk, i_rst_n, r_phase == PH_VAL, r_bytes_left != 8'd0)
    `TLV8P_ASSERT_NEXT(a_frame_end_clears, i_clk, i_rst_n, i_step && last, (r_phase == PH_TAG) && !r_item_open)
    `TLV8P_ASSERT_IMPL(a_first_only_in_val, i_clk, i_rst_n, r_first_pending, r_phase == PH_VAL)

endmodule

// ----- hw/rtl/tlv8p_out_reg.sv -----
// result register of the tlv8 fragment parser
module tlv8p_out_reg
    import tlv8p_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // slot can take a result when empty or being drained this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/tlv8_fragment_parser_unit.sv -----
// top level of the tlv8 fragment parser: input register, parser, result register
//
// usage
// - input channel: one frame byte per item on i_byte_in, i_frame_last high on the
//   last byte of a frame; taken at a clock edge with i_valid high and o_stall low
// - output channel: one result item per value byte, empty-item marker or
//   end-of-frame status; taken at a clock edge with o_valid high and i_stall low
// - bytes that are headers and cause no result simply vanish inside the block
// - a taken byte waits in the input register and is decoded into the result register
//   once the result slot is free; the result is offered from the result register
// - throughput: one byte per cycle while the receiver does not stall; the decode is
//   a single step on the small parse state, so the input register drains into the
//   result register each cycle unless a result is held there by a receiver stall
// - stall: when the receiver stalls with a result waiting, the byte in the input
//   register holds and o_stall rises once that register is full; o_valid and the
//   result payload stay put until taken
// - on error status (truncated header or value) the receiver drops the frame
// - reset (i_rst_n low, synchronous): both registers empty, parser expects a tag
// - every frame end returns the parser to its reset state, no merge across frames
`include "tlv8_fragment_parser_unit_assert.svh"
module tlv8_fragment_parser_unit
    import tlv8p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_frame_last,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_item_type,
    output logic [7:0] o_value_byte,
    output logic       o_starts_item,
    output logic       o_frame_done,
    output logic [1:0] o_status
);

    t_in_item in_item;
    t_in_item held_item;
    logic     held;
    logic     out_free;
    logic     advance;
    logic     has_result;
    t_result  result;
    t_result  out_result;

    assign in_item.byte_in    = i_byte_in;
    assign in_item.frame_last = i_frame_last;

    // a held byte is decoded when the result slot can take whatever it produces
    assign advance = held && out_free;

    tlv8p_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .o_stall   (o_stall),
        .i_advance (advance),
        .o_held    (held),
        .o_item    (held_item)
    );

    tlv8p_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_item       (held_item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    tlv8p_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_kind        = out_result.kind;
    assign o_item_type   = out_result.item_type;
    assign o_value_byte  = out_result.value_byte;
    assign o_starts_item = out_result.starts_item;
    assign o_frame_done  = out_result.frame_done;
    assign o_status      = out_result.status;

    `TLV8P_ASSERT_IMPL(a_status_only_at_end, i_clk, i_rst_n, o_valid && !o_frame_done, o_status == ST_OK)
    `TLV8P_ASSERT_IMPL(a_value_zero_off_data, i_clk, i_rst_n, o_valid && (o_kind != KIND_VALUE), o_value_byte == 8'd0)
    `TLV8P_ASSERT_IMPL(a_stall_needs_held, i_clk, i_rst_n, o_stall, held && o_valid && i_stall)

endmodule
